@@ rtl/core/krm_pkg.sv @@
// Shared types and keyword tables for the keyword response matcher.
package krm_pkg;

  // Number of keyword slots in the table, and the longest keyword.
  localparam int KW_SLOTS  = 6;
  localparam int KW_MAXLEN = 5;

  // Field and counter widths.
  localparam int BYTE_W = 8;
  localparam int ID_W   = 3;
  localparam int PROG_W = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ID_W-1:0]   kw_id_t;
  typedef logic [PROG_W-1:0] prog_t;

  // Keyword characters; unused tail positions hold zero.
  localparam byte_t KW_TEXT [KW_SLOTS][KW_MAXLEN] = '{
    '{"t", "e", "m", "p", ":"},
    '{"g", "a", "s", ":", 8'h00},
    '{"p", "r", "e", "s", ":"},
    '{"l", "a", "t", ":", 8'h00},
    '{"l", "o", "n", ":", 8'h00},
    '{"R", "E", "A", "D", "Y"}
  };

  // Keyword lengths.
  localparam prog_t KW_LEN [KW_SLOTS] = '{
    3'd5, 3'd4, 3'd5, 3'd4, 3'd4, 3'd5
  };

  // Outcome of one byte against all keywords.
  typedef struct packed {
    logic   hit;
    kw_id_t id;
  } match_t;

endpackage

@@ rtl/core/krm_if.sv @@
// Valid/ready channel interfaces for received bytes and matched keywords.
interface krm_in_if;
  import krm_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface krm_out_if;
  import krm_pkg::*;
  logic   valid;
  logic   ready;
  kw_id_t keyword_id;

  modport source (output valid, output keyword_id, input ready);
  modport sink (input valid, input keyword_id, output ready);
endinterface

@@ rtl/core/krm_match.sv @@
// Parallel compare of one byte against every watched keyword.
module krm_match
  import krm_pkg::*;
#(
  parameter int NUM_KEYWORDS = 6
) (
  input  byte_t                             rx_byte,
  input  logic [NUM_KEYWORDS-1:0][PROG_W-1:0] prog,
  output logic [NUM_KEYWORDS-1:0][PROG_W-1:0] prog_nxt,
  output match_t                            match
);

  logic [NUM_KEYWORDS-1:0][PROG_W-1:0] adv;

  // Advance or clear each counter; a later keyword overrides an earlier hit.
  always_comb begin
    adv          = '0;
    match.hit    = 1'b0;
    match.id     = '0;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if ((prog[k] < KW_LEN[k]) && (KW_TEXT[k][prog[k]] == rx_byte)) begin
        adv[k] = prog[k] + 3'd1;
        if (adv[k] == KW_LEN[k]) begin
          match.hit = 1'b1;
          match.id  = kw_id_t'(k);
        end
      end
    end
  end

  // A completed keyword clears every counter.
  assign prog_nxt = match.hit ? '0 : adv;

endmodule

@@ rtl/core/keyword_response_matcher_top.sv @@
// Top level of the keyword response matcher: input register, match stage, result register.
//
// The block takes one received byte per cycle. It presents the index of any keyword that
// the byte completes (0 temp:, 1 gas:, 2 pres:, 3 lat:, 4 lon:, 5 READY) from the result
// register once the byte has moved on from the input register. Bytes that complete
// nothing give no result. A byte is registered on entry, compared against all keywords
// combinationally, and a hit waits in the result register. While the result register
// is full and its request is not taken, the byte in the input register waits and the
// input side stalls, whether or not that byte completes a keyword. With the result side
// ready, one byte is taken every cycle. A mismatching byte only clears that keyword's
// counter and is not tried as a new first character, and any completed keyword clears
// all counters.
module keyword_response_matcher_top
  import krm_pkg::*;
#(
  parameter int NUM_KEYWORDS = 6
) (
  input logic clk,
  input logic rst_n,
  krm_in_if.sink    in_ch,
  krm_out_if.source out_ch
);

  // Input register.
  logic  in_valid_r;
  byte_t in_byte_r;

  // Match progress counters and result register.
  logic [NUM_KEYWORDS-1:0][PROG_W-1:0] prog_r;
  logic [NUM_KEYWORDS-1:0][PROG_W-1:0] prog_nxt;
  logic   out_valid_r;
  kw_id_t out_id_r;

  match_t match;
  logic   stage_fire;
  logic   out_free;

  krm_match #(
    .NUM_KEYWORDS (NUM_KEYWORDS)
  ) u_match (
    .rx_byte  (in_byte_r),
    .prog     (prog_r),
    .prog_nxt (prog_nxt),
    .match    (match)
  );

  // The registered byte moves on when the result register can take its outcome.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign stage_fire  = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || stage_fire;

  // Input register load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // Counter update once per processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_r <= '0;
    end else if (stage_fire) begin
      prog_r <= prog_nxt;
    end
  end

  // Result register holds a hit until the request is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= stage_fire && match.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && match.hit) begin
      out_id_r <= match.id;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.keyword_id = out_id_r;

  // A hit clears every counter.
  assert property (@(posedge clk) disable iff (!rst_n)
    (stage_fire && match.hit) |=> (prog_r == '0))
    else $error("counters not cleared after a keyword hit");

  // A reported keyword is one that is watched.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_id_r < kw_id_t'(NUM_KEYWORDS)))
    else $error("reported keyword index out of range");

  // A byte in the input register is not dropped while the result register is full and not taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_free) |=> (in_valid_r && $stable(in_byte_r)))
    else $error("stalled byte lost from the input register");

  // Every counter stays below its keyword length.
  for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_prog_chk
    assert property (@(posedge clk) disable iff (!rst_n)
      prog_r[k] < KW_LEN[k])
      else $error("keyword progress counter reached its length");
  end

endmodule

@@ tb/testbench.sv @@
// Testbench for the keyword response matcher: byte stimulus, prediction and result checks.
module testbench;
  import krm_pkg::*;

  localparam int KEYWORDS   = 6;
  localparam int BYTE_COUNT = 1550;
  localparam int TAIL_WAIT  = 12;

  // Shapes of the random byte sequences.
  typedef enum int {
    SEQ_WHOLE,
    SEQ_BROKEN,
    SEQ_NOISE,
    SEQ_CHARSET
  } seq_kind_t;

  // Tracks keyword progress over accepted requests and holds the keyword hits still due.
  class kw_scoreboard;
    prog_t  progress [KW_SLOTS];
    kw_id_t hits_due [$];
    int unsigned errors;

    function new();
      foreach (progress[k]) progress[k] = '0;
      errors = 0;
    endfunction

    function int pending();
      return hits_due.size();
    endfunction

    // Advance every watched keyword on one byte; a completed keyword clears all counters.
    function void note_byte(byte_t b);
      bit     hit;
      kw_id_t which;
      hit   = 1'b0;
      which = '0;
      for (int k = 0; k < KW_SLOTS && k < KEYWORDS; k++) begin
        if (progress[k] < KW_LEN[k] && KW_TEXT[k][progress[k]] == b) begin
          progress[k] = progress[k] + 1'b1;
          if (progress[k] == KW_LEN[k]) begin
            hit   = 1'b1;
            which = kw_id_t'(k);
          end
        end else begin
          progress[k] = '0;
        end
      end
      if (hit) begin
        foreach (progress[k]) progress[k] = '0;
        hits_due.push_back(which);
      end
    endfunction

    // Compare one reported keyword with the oldest hit still due.
    function void check_result(kw_id_t id);
      kw_id_t due;
      if (hits_due.size() == 0) begin
        $error("keyword_id unexpected: expected none, actual %0d", id);
        errors++;
      end else begin
        due = hits_due.pop_front();
        if (due !== id) begin
          $error("keyword_id mismatch: expected %0d, actual %0d", due, id);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  krm_in_if  in_ch ();
  krm_out_if out_ch ();

  kw_scoreboard sb;
  int unsigned  bytes_sent;
  int unsigned  burst_left;
  int unsigned  rx_phase;
  byte_t        seq_q [$];

  keyword_response_matcher_top #(
    .NUM_KEYWORDS(KEYWORDS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Clock with a period of 20.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Fill the sequence queue with bytes of the given shape.
  function automatic void build_seq(seq_kind_t kind);
    int unsigned k;
    int unsigned cut;
    int unsigned n;
    seq_q.delete();
    k = $urandom_range(KEYWORDS - 1);
    case (kind)
      SEQ_WHOLE: begin
        for (int i = 0; i < int'(KW_LEN[k]); i++) seq_q.push_back(KW_TEXT[k][i]);
      end
      SEQ_BROKEN: begin
        cut = $urandom_range(1, int'(KW_LEN[k]) - 1);
        for (int i = 0; i < int'(cut); i++) seq_q.push_back(KW_TEXT[k][i]);
        seq_q.push_back(byte_t'($urandom_range(255)));
      end
      SEQ_NOISE: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < int'(n); i++) seq_q.push_back(byte_t'($urandom_range(255)));
      end
      SEQ_CHARSET: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < int'(n); i++) begin
          k   = $urandom_range(KEYWORDS - 1);
          cut = $urandom_range(int'(KW_LEN[k]) - 1);
          seq_q.push_back(KW_TEXT[k][cut]);
        end
      end
      default: begin
        seq_q.push_back(byte_t'($urandom_range(255)));
      end
    endcase
  endfunction

  // Present one byte and hold it until its request is accepted.
  task automatic send_byte(input byte_t b);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Leave the input idle for a number of cycles.
  task automatic idle_cycles(input int unsigned n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending until every expected result has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Send one byte inside a burst, with a random gap between bursts.
  task automatic drive_byte(input byte_t b);
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 6));
      burst_left = $urandom_range(1, 16);
    end
    send_byte(b);
    burst_left--;
  endtask

  // Receiver with a stall pattern of its own.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_phase     <= 0;
    end else begin
      out_ch.ready <= ((rx_phase % 11) < 7) && ((rx_phase % 97) >= 12);
      rx_phase     <= rx_phase + 1;
    end
  end

  // Observe both channels in one process so input and output bookkeeping keep a fixed order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.keyword_id);
    end
  end

  // Reset, stimulus and the final verdict.
  initial begin
    int unsigned pick;
    seq_kind_t   kind;
    bit          paused;
    sb            = new();
    bytes_sent    = 0;
    burst_left    = 0;
    paused        = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_sent < BYTE_COUNT) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        kind = SEQ_WHOLE;
      end else if (pick < 6) begin
        kind = SEQ_BROKEN;
      end else if (pick < 8) begin
        kind = SEQ_NOISE;
      end else begin
        kind = SEQ_CHARSET;
      end
      build_seq(kind);
      foreach (seq_q[i]) drive_byte(seq_q[i]);
      if (!paused && bytes_sent >= BYTE_COUNT / 2) begin
        paused = 1'b1;
        drain();
      end
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop for a hung run.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/krm_pkg.sv
rtl/core/krm_if.sv
rtl/core/krm_match.sv
rtl/core/keyword_response_matcher_top.sv
tb/testbench.sv
